// ----- design/lcc_pkg.sv -----
// Shared types and constants for the card number Luhn check core.
package lcc_pkg;

  // Card number field width and number of decimal digit cells
  localparam int CARD_W     = 63;
  localparam int NUM_DIGITS = 19;
  localparam int COUNT_W    = 5;

  // Brand codes as they appear on the result beat
  typedef enum logic [1:0] {
    BRAND_INVALID = 2'd0,
    BRAND_AMEX    = 2'd1,
    BRAND_MC      = 2'd2,
    BRAND_VISA    = 2'd3
  } brand_t;

  // What every digit cell does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_CLEAR  = 2'd1,
    CELL_SHIFT  = 2'd2,
    CELL_UNLOAD = 2'd3
  } cell_mode_t;

  // Control from the sequencer to the digit digest
  typedef struct packed {
    logic               clear;
    logic               take;
    logic [COUNT_W-1:0] pos;
  } digest_ctl_t;

endpackage

// ----- design/lcc_cell.sv -----
// One BCD digit cell of the shift-and-add-3 converter chain.
module lcc_cell (
  input  logic                clk,
  input  lcc_pkg::cell_mode_t mode,
  input  logic                carry_in,
  input  logic [3:0]          upper_digit,
  output logic                carry_out,
  output logic [3:0]          digit
);

  logic [3:0] adj;
  logic [3:0] digit_next;

  // Add 3 when the digit would reach ten after doubling
  assign adj       = (digit >= 4'd5) ? (digit + 4'd3) : digit;
  assign carry_out = adj[3];

  always_comb begin
    case (mode)
      lcc_pkg::CELL_CLEAR:  digit_next = 4'd0;
      lcc_pkg::CELL_SHIFT:  digit_next = {adj[2:0], carry_in};
      lcc_pkg::CELL_UNLOAD: digit_next = upper_digit;
      default:              digit_next = digit;
    endcase
  end

  always_ff @(posedge clk) begin
    digit <= digit_next;
  end

endmodule

// ----- design/lcc_digest.sv -----
// Digit digest: running Luhn sum mod 10, digit count and leading digits.
module lcc_digest (
  input  logic                         clk,
  input  lcc_pkg::digest_ctl_t         ctl,
  input  logic [3:0]                   digit,
  output logic [lcc_pkg::COUNT_W-1:0]  digit_count,
  output logic                         luhn_ok,
  output lcc_pkg::brand_t              brand
);

  logic [3:0]                  sum;
  logic [3:0]                  top;
  logic [3:0]                  second;
  logic [3:0]                  prev;
  logic [lcc_pkg::COUNT_W-1:0] count;

  logic [4:0] dbl;
  logic [3:0] term;
  logic [4:0] acc;
  logic [3:0] sum_next;

  // Odd positions double the digit and fold the tens back in
  assign dbl  = {digit, 1'b0};
  assign term = !ctl.pos[0] ? digit :
                (digit >= 4'd5) ? 4'(dbl - 5'd9) : dbl[3:0];

  // Running sum kept mod 10
  assign acc      = {1'b0, sum} + {1'b0, term};
  assign sum_next = (acc >= 5'd10) ? 4'(acc - 5'd10) : acc[3:0];

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      sum    <= 4'd0;
      count  <= '0;
      top    <= 4'd0;
      second <= 4'd0;
      prev   <= 4'd0;
    end else if (ctl.take) begin
      sum  <= sum_next;
      prev <= digit;
      // Highest nonzero digit seen so far sets the count and the prefix
      if (digit != 4'd0) begin
        count  <= ctl.pos + 1'b1;
        top    <= digit;
        second <= prev;
      end
    end
  end

  assign digit_count = count;
  assign luhn_ok     = (sum == 4'd0);

  // Brand from length and the two leading digits, invalid unless luhn_ok
  always_comb begin
    brand = lcc_pkg::BRAND_INVALID;
    if (luhn_ok) begin
      case (count)
        5'd13: if (top == 4'd4) brand = lcc_pkg::BRAND_VISA;
        5'd15: if (top == 4'd3 && (second == 4'd4 || second == 4'd7))
                 brand = lcc_pkg::BRAND_AMEX;
        5'd16: begin
          if (top == 4'd5 && second >= 4'd1 && second <= 4'd5)
            brand = lcc_pkg::BRAND_MC;
          else if (top == 4'd4)
            brand = lcc_pkg::BRAND_VISA;
        end
        default: brand = lcc_pkg::BRAND_INVALID;
      endcase
    end
  end

endmodule

// ----- design/card_number_luhn_check_core.sv -----
// Top level: bit-serial binary to BCD chain, digit unload and Luhn digest.
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  input   | in_valid, in_stall, card_number       | in beat
//  output  | out_valid, out_stall, digit_count,    | out beat
//          | luhn_ok, brand                        |
//
// From accept to result, a beat shifts the number MSB first into a chain
// of 19 BCD cells, unloads the digits into the digest, then loads the
// result register once the output is free.
// rst is synchronous and clears the sequencer and the result valid.
// A new beat is taken while a finished result still waits in the output
// register; a stalled output holds the next result back in the done state.
module card_number_luhn_check_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lcc_pkg::CARD_W-1:0]    card_number,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lcc_pkg::COUNT_W-1:0]   digit_count,
  output logic                          luhn_ok,
  output logic [1:0]                    brand
);

  localparam int BIT_W = $clog2(lcc_pkg::CARD_W);
  localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(lcc_pkg::CARD_W - 1);
  localparam logic [lcc_pkg::COUNT_W-1:0] LAST_POS =
    lcc_pkg::COUNT_W'(lcc_pkg::NUM_DIGITS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_UNLOAD,
    ST_DONE
  } state_t;

  state_t                        state;
  logic [lcc_pkg::CARD_W-1:0]    shreg;
  logic [BIT_W-1:0]              bit_cnt;
  logic [lcc_pkg::COUNT_W-1:0]   pos;

  logic                          accept;
  logic                          out_free;
  lcc_pkg::cell_mode_t           mode;
  lcc_pkg::digest_ctl_t          dctl;
  logic [3:0]                    digit_q [lcc_pkg::NUM_DIGITS];
  logic                          carry   [lcc_pkg::NUM_DIGITS];

  logic [lcc_pkg::COUNT_W-1:0]   dg_count;
  logic                          dg_luhn_ok;
  lcc_pkg::brand_t               dg_brand;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Cell mode per phase
  always_comb begin
    case (state)
      ST_IDLE:   mode = accept ? lcc_pkg::CELL_CLEAR : lcc_pkg::CELL_HOLD;
      ST_CONV:   mode = lcc_pkg::CELL_SHIFT;
      ST_UNLOAD: mode = lcc_pkg::CELL_UNLOAD;
      default:   mode = lcc_pkg::CELL_HOLD;
    endcase
  end

  assign dctl.clear = accept;
  assign dctl.take  = (state == ST_UNLOAD);
  assign dctl.pos   = pos;

  // Chain of digit cells, binary bits enter at the least significant cell
  assign carry[0] = shreg[lcc_pkg::CARD_W-1];

  for (genvar i = 0; i < lcc_pkg::NUM_DIGITS; i++) begin : g_cell
    if (i == lcc_pkg::NUM_DIGITS - 1) begin : g_top
      lcc_cell u_cell (
        .clk         (clk),
        .mode        (mode),
        .carry_in    (carry[i]),
        .upper_digit (4'd0),
        .carry_out   (),
        .digit       (digit_q[i])
      );
    end else begin : g_mid
      lcc_cell u_cell (
        .clk         (clk),
        .mode        (mode),
        .carry_in    (carry[i]),
        .upper_digit (digit_q[i+1]),
        .carry_out   (carry[i+1]),
        .digit       (digit_q[i])
      );
    end
  end

  lcc_digest u_digest (
    .clk         (clk),
    .ctl         (dctl),
    .digit       (digit_q[0]),
    .digit_count (dg_count),
    .luhn_ok     (dg_luhn_ok),
    .brand       (dg_brand)
  );

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      bit_cnt   <= '0;
      pos       <= '0;
    end else begin
      // Result valid: set when a result loads, cleared when it is taken
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            shreg   <= card_number;
            bit_cnt <= '0;
            state   <= ST_CONV;
          end
        end
        ST_CONV: begin
          shreg   <= {shreg[lcc_pkg::CARD_W-2:0], 1'b0};
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == LAST_BIT) begin
            pos   <= '0;
            state <= ST_UNLOAD;
          end
        end
        ST_UNLOAD: begin
          pos <= pos + 1'b1;
          if (pos == LAST_POS) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            digit_count <= dg_count;
            luhn_ok     <= dg_luhn_ok;
            brand       <= dg_brand;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
